[sv/isi_pkg.sv]
package isi_pkg;

  localparam int H_W    = 24;   // thickness
  localparam int T_W    = 48;   // tensor components and result
  localparam int V_W    = 32;   // velocity components
  localparam int TS_W   = 49;   // sums and differences of two tensor components
  localparam int P_W    = 112;  // tensor component times velocity product
  localparam int SUM_W  = 114;  // signed along-flow numerator before scaling
  localparam int DEN_W  = 88;   // thickness times speed squared
  localparam int SQ_W   = 98;   // d^2 + s^2
  localparam int X_W    = 112;  // radicand
  localparam int ROOT_W = 56;
  localparam int REM_W  = 60;
  localparam int M_W    = 120;  // numerator magnitude
  localparam int N_W    = 121;  // 2m + den
  localparam int D_W    = 89;   // 2 den
  localparam int R_W    = 137;  // divider remainder
  localparam int Q_W    = 48;

  localparam int SQRT_STAGES = X_W / 2;
  localparam int DIV_STAGES  = Q_W;

  localparam logic [Q_W-1:0] POS_LIMIT = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_PRINCIPAL  = 2'd0,
    MODE_ALONG_FLOW = 2'd1,
    MODE_TRACE      = 2'd2
  } mode_t;

  typedef struct packed {
    logic [H_W-1:0]   h;
    logic [TS_W-1:0]  t;
    logic [SUM_W-1:0] sum1;
    logic [DEN_W-1:0] den1;
    logic             uz;
  } carry_t;

endpackage

[sv/isi_if.sv]
interface isi_in_if;
  import isi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [H_W-1:0]        thickness;
  logic signed [T_W-1:0] tensor_xx;
  logic signed [T_W-1:0] tensor_xy;
  logic signed [T_W-1:0] tensor_yx;
  logic signed [T_W-1:0] tensor_yy;
  logic signed [V_W-1:0] velocity_x;
  logic signed [V_W-1:0] velocity_y;
  modport source (output valid, thickness, tensor_xx, tensor_xy, tensor_yx, tensor_yy,
                  velocity_x, velocity_y, input ready);
  modport sink (input valid, thickness, tensor_xx, tensor_xy, tensor_yx, tensor_yy,
                velocity_x, velocity_y, output ready);
endinterface

interface isi_out_if;
  import isi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [T_W-1:0] stress_measure;
  logic                  saturated;
  modport source (output valid, stress_measure, saturated, input ready);
  modport sink (input valid, stress_measure, saturated, output ready);
endinterface

interface isi_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] measure_mode;
  modport source (output valid, measure_mode, input ready);
  modport sink (input valid, measure_mode, output ready);
endinterface

[sv/ice_stress_invariant.sv]
// Most of the pipeline lies in the 56-stage square root (one root bit per stage) and
// the 48-stage divider.
// Throughput: one cell per clock; a stalled output freezes the pipeline, and
// the first stage still takes one beat while it is empty.
// Reset (rst_n low, synchronous) clears all valid bits and sets the mode to principal.
module ice_stress_invariant (
  input logic     clk,
  input logic     rst_n,
  isi_in_if.sink  in_ch,
  isi_out_if.source out_ch,
  isi_cfg_if.sink cfg_ch
);
  import isi_pkg::*;

  function automatic logic [TS_W-1:0] mag49(logic [TS_W-1:0] v);
    return v[TS_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [T_W-1:0] mag48(logic [T_W-1:0] v);
    return v[T_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [V_W-1:0] mag32(logic [V_W-1:0] v);
    return v[V_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [57:0] mag58(logic [57:0] v);
    return v[57] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [SUM_W-1:0] mag114(logic [SUM_W-1:0] v);
    return v[SUM_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [SUM_W-1:0] signed114(logic [P_W-1:0] p, logic n);
    logic [SUM_W-1:0] e;
    e = {2'b00, p};
    return n ? (~e + 1'b1) : e;
  endfunction

  // configuration
  logic [1:0] mode_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PRINCIPAL;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.measure_mode;
    end
  end

  // pipeline control
  logic out_v_r;
  logic a_v_r;
  logic adv;
  logic ld_a;
  assign adv = !out_v_r || out_ch.ready;
  assign ld_a = adv || !a_v_r;
  assign in_ch.ready = ld_a;

  // stage A: sums, differences, velocity magnitudes
  logic [TS_W-1:0] a_t_nxt, a_d_nxt, a_s_nxt;
  logic [TS_W-1:0] a_d_r, a_s_r;
  logic [T_W-1:0]  a_txx_r, a_tyy_r;
  logic [V_W-1:0]  a_ax_r, a_ay_r;
  logic            a_xyneg_r;
  carry_t          a_c_nxt, a_c_r;

  always_comb begin
    a_t_nxt = {in_ch.tensor_xx[T_W-1], in_ch.tensor_xx}
            + {in_ch.tensor_yy[T_W-1], in_ch.tensor_yy};
    a_d_nxt = {in_ch.tensor_xx[T_W-1], in_ch.tensor_xx}
            - {in_ch.tensor_yy[T_W-1], in_ch.tensor_yy};
    a_s_nxt = {in_ch.tensor_xy[T_W-1], in_ch.tensor_xy}
            + {in_ch.tensor_yx[T_W-1], in_ch.tensor_yx};
    a_c_nxt      = '0;
    a_c_nxt.h    = in_ch.thickness;
    a_c_nxt.t    = a_t_nxt;
    a_c_nxt.uz   = (in_ch.velocity_x == '0) && (in_ch.velocity_y == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (ld_a) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_d_r     <= a_d_nxt;
      a_s_r     <= a_s_nxt;
      a_txx_r   <= in_ch.tensor_xx;
      a_tyy_r   <= in_ch.tensor_yy;
      a_ax_r    <= mag32(in_ch.velocity_x);
      a_ay_r    <= mag32(in_ch.velocity_y);
      a_xyneg_r <= in_ch.velocity_x[V_W-1] ^ in_ch.velocity_y[V_W-1];
      a_c_r     <= a_c_nxt;
    end
  end

  // stage B: magnitudes and velocity products
  logic            b_v_r;
  logic [TS_W-1:0] b_md_r, b_ms_r;
  logic [T_W-1:0]  b_mtxx_r, b_mtyy_r;
  logic            b_ntxx_r, b_ntyy_r, b_ns_r;
  logic [63:0]     b_uxx_nxt, b_uyy_nxt, b_uxy_nxt;
  logic [63:0]     b_uxx_r, b_uyy_r, b_uxy_r;
  carry_t          b_c_r;

  always_comb begin
    b_uxx_nxt = a_ax_r * a_ax_r;
    b_uyy_nxt = a_ay_r * a_ay_r;
    b_uxy_nxt = a_ax_r * a_ay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_md_r   <= mag49(a_d_r);
      b_ms_r   <= mag49(a_s_r);
      b_mtxx_r <= mag48(a_txx_r);
      b_mtyy_r <= mag48(a_tyy_r);
      b_ntxx_r <= a_txx_r[T_W-1];
      b_ntyy_r <= a_tyy_r[T_W-1];
      b_ns_r   <= a_s_r[TS_W-1] ^ a_xyneg_r;
      b_uxx_r  <= b_uxx_nxt;
      b_uyy_r  <= b_uyy_nxt;
      b_uxy_r  <= b_uxy_nxt;
      b_c_r    <= a_c_r;
    end
  end

  // stage C: partial products
  logic        c_v_r;
  logic [63:0] c_pd_ll_nxt, c_ps_ll_nxt;
  logic [48:0] c_pd_lh_nxt, c_ps_lh_nxt;
  logic [33:0] c_pd_hh_nxt, c_ps_hh_nxt;
  logic [63:0] c_px00_nxt, c_px01_nxt, c_py00_nxt, c_py01_nxt, c_pz00_nxt, c_pz01_nxt;
  logic [47:0] c_px10_nxt, c_px11_nxt, c_py10_nxt, c_py11_nxt;
  logic [48:0] c_pz10_nxt, c_pz11_nxt;
  logic [63:0] c_pd_ll_r, c_ps_ll_r;
  logic [48:0] c_pd_lh_r, c_ps_lh_r;
  logic [33:0] c_pd_hh_r, c_ps_hh_r;
  logic [63:0] c_px00_r, c_px01_r, c_py00_r, c_py01_r, c_pz00_r, c_pz01_r;
  logic [47:0] c_px10_r, c_px11_r, c_py10_r, c_py11_r;
  logic [48:0] c_pz10_r, c_pz11_r;
  logic [63:0] c_usum_r;
  logic        c_ntxx_r, c_ntyy_r, c_ns_r;
  carry_t      c_c_r;

  always_comb begin
    c_pd_ll_nxt = b_md_r[31:0] * b_md_r[31:0];
    c_pd_lh_nxt = b_md_r[31:0] * b_md_r[48:32];
    c_pd_hh_nxt = b_md_r[48:32] * b_md_r[48:32];
    c_ps_ll_nxt = b_ms_r[31:0] * b_ms_r[31:0];
    c_ps_lh_nxt = b_ms_r[31:0] * b_ms_r[48:32];
    c_ps_hh_nxt = b_ms_r[48:32] * b_ms_r[48:32];
    c_px00_nxt  = b_mtxx_r[31:0] * b_uxx_r[31:0];
    c_px01_nxt  = b_mtxx_r[31:0] * b_uxx_r[63:32];
    c_px10_nxt  = b_mtxx_r[47:32] * b_uxx_r[31:0];
    c_px11_nxt  = b_mtxx_r[47:32] * b_uxx_r[63:32];
    c_py00_nxt  = b_mtyy_r[31:0] * b_uyy_r[31:0];
    c_py01_nxt  = b_mtyy_r[31:0] * b_uyy_r[63:32];
    c_py10_nxt  = b_mtyy_r[47:32] * b_uyy_r[31:0];
    c_py11_nxt  = b_mtyy_r[47:32] * b_uyy_r[63:32];
    c_pz00_nxt  = b_ms_r[31:0] * b_uxy_r[31:0];
    c_pz01_nxt  = b_ms_r[31:0] * b_uxy_r[63:32];
    c_pz10_nxt  = b_ms_r[48:32] * b_uxy_r[31:0];
    c_pz11_nxt  = b_ms_r[48:32] * b_uxy_r[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_pd_ll_r <= c_pd_ll_nxt;
      c_pd_lh_r <= c_pd_lh_nxt;
      c_pd_hh_r <= c_pd_hh_nxt;
      c_ps_ll_r <= c_ps_ll_nxt;
      c_ps_lh_r <= c_ps_lh_nxt;
      c_ps_hh_r <= c_ps_hh_nxt;
      c_px00_r  <= c_px00_nxt;
      c_px01_r  <= c_px01_nxt;
      c_px10_r  <= c_px10_nxt;
      c_px11_r  <= c_px11_nxt;
      c_py00_r  <= c_py00_nxt;
      c_py01_r  <= c_py01_nxt;
      c_py10_r  <= c_py10_nxt;
      c_py11_r  <= c_py11_nxt;
      c_pz00_r  <= c_pz00_nxt;
      c_pz01_r  <= c_pz01_nxt;
      c_pz10_r  <= c_pz10_nxt;
      c_pz11_r  <= c_pz11_nxt;
      c_usum_r  <= b_uxx_r + b_uyy_r;  // at most 2^63
      c_ntxx_r  <= b_ntxx_r;
      c_ntyy_r  <= b_ntyy_r;
      c_ns_r    <= b_ns_r;
      c_c_r     <= b_c_r;
    end
  end

  // stage D: reduce partial products, thickness times speed squared
  logic             d_v_r;
  logic [SQ_W-1:0]  d_sqd_nxt, d_sqs_nxt, d_sqd_r, d_sqs_r;
  logic [P_W-1:0]   d_pxx_nxt, d_pyy_nxt, d_pzz_nxt, d_pxx_r, d_pyy_r, d_pzz_r;
  logic [55:0]      d_hl_nxt, d_hh_nxt, d_hl_r, d_hh_r;
  logic             d_ntxx_r, d_ntyy_r, d_ns_r;
  carry_t           d_c_r;

  always_comb begin
    d_sqd_nxt = (SQ_W'(c_pd_hh_r) << 64) + (SQ_W'(c_pd_lh_r) << 33) + SQ_W'(c_pd_ll_r);
    d_sqs_nxt = (SQ_W'(c_ps_hh_r) << 64) + (SQ_W'(c_ps_lh_r) << 33) + SQ_W'(c_ps_ll_r);
    d_pxx_nxt = (P_W'(c_px11_r) << 64) + ((P_W'(c_px01_r) + P_W'(c_px10_r)) << 32)
              + P_W'(c_px00_r);
    d_pyy_nxt = (P_W'(c_py11_r) << 64) + ((P_W'(c_py01_r) + P_W'(c_py10_r)) << 32)
              + P_W'(c_py00_r);
    d_pzz_nxt = (P_W'(c_pz11_r) << 64) + ((P_W'(c_pz01_r) + P_W'(c_pz10_r)) << 32)
              + P_W'(c_pz00_r);
    d_hl_nxt  = c_c_r.h * c_usum_r[31:0];
    d_hh_nxt  = c_c_r.h * c_usum_r[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sqd_r  <= d_sqd_nxt;
      d_sqs_r  <= d_sqs_nxt;
      d_pxx_r  <= d_pxx_nxt;
      d_pyy_r  <= d_pyy_nxt;
      d_pzz_r  <= d_pzz_nxt;
      d_hl_r   <= d_hl_nxt;
      d_hh_r   <= d_hh_nxt;
      d_ntxx_r <= c_ntxx_r;
      d_ntyy_r <= c_ntyy_r;
      d_ns_r   <= c_ns_r;
      d_c_r    <= c_c_r;
    end
  end

  // stage E feeds the square root pipeline (index 0)
  logic              sq_v_r    [0:SQRT_STAGES];
  logic [X_W-1:0]    sq_x_r    [0:SQRT_STAGES];
  logic [ROOT_W-1:0] sq_root_r [0:SQRT_STAGES];
  logic [REM_W-1:0]  sq_rem_r  [0:SQRT_STAGES];
  carry_t            sq_c_r    [0:SQRT_STAGES];
  logic [SQ_W-1:0]   e_sq_nxt;
  carry_t            e_c_nxt;

  always_comb begin
    e_sq_nxt     = d_sqd_r + d_sqs_r;
    e_c_nxt      = d_c_r;
    e_c_nxt.sum1 = signed114(d_pxx_r, d_ntxx_r) + signed114(d_pyy_r, d_ntyy_r)
                 + signed114(d_pzz_r, d_ns_r);
    e_c_nxt.den1 = (DEN_W'(d_hh_r) << 32) + DEN_W'(d_hl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r[0]    <= {e_sq_nxt, 14'b0};
      sq_root_r[0] <= '0;
      sq_rem_r[0]  <= '0;
      sq_c_r[0]    <= e_c_nxt;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      rem_sh = {sq_rem_r[k][REM_W-3:0], sq_x_r[k][X_W-1 -: 2]};
      trial  = {2'b00, sq_root_r[k], 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x_r[k+1]    <= sq_x_r[k] << 2;
        sq_root_r[k+1] <= {sq_root_r[k][ROOT_W-2:0], ge};
        sq_rem_r[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_c_r[k+1]    <= sq_c_r[k];
      end
    end
  end

  // stage F: pick numerator and denominator for the mode
  logic             f_v_r, f_neg_r, f_zero_r;
  logic [M_W-1:0]   f_m_r;
  logic [DEN_W-1:0] f_den_r;
  logic             f_neg_nxt, f_zero_nxt;
  logic [M_W-1:0]   f_m_nxt;
  logic [DEN_W-1:0] f_den_nxt;
  logic [57:0]      f_n0, f_n2;
  logic [SUM_W-1:0] f_msum;
  carry_t           f_c;

  always_comb begin
    f_c    = sq_c_r[SQRT_STAGES];
    f_n0   = {{2{f_c.t[TS_W-1]}}, f_c.t, 7'b0} + {2'b00, sq_root_r[SQRT_STAGES]};
    f_n2   = {f_c.t[TS_W-1], f_c.t, 8'b0};
    f_msum = mag114(f_c.sum1);
    f_zero_nxt = (f_c.h == '0);
    case (mode_r)
      MODE_PRINCIPAL: begin
        f_neg_nxt = f_n0[57];
        f_m_nxt   = M_W'(mag58(f_n0));
        f_den_nxt = DEN_W'(f_c.h);
      end
      MODE_ALONG_FLOW: begin
        f_neg_nxt  = f_c.sum1[SUM_W-1];
        f_m_nxt    = {f_msum[P_W-1:0], 8'b0};
        f_den_nxt  = f_c.den1;
        f_zero_nxt = f_zero_nxt || f_c.uz;
      end
      MODE_TRACE: begin
        f_neg_nxt = f_n2[57];
        f_m_nxt   = M_W'(mag58(f_n2));
        f_den_nxt = DEN_W'(f_c.h);
      end
      default: begin
        f_neg_nxt  = 1'b0;
        f_m_nxt    = '0;
        f_den_nxt  = '0;
        f_zero_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= sq_v_r[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_neg_r  <= f_neg_nxt;
      f_zero_r <= f_zero_nxt;
      f_m_r    <= f_m_nxt;
      f_den_r  <= f_den_nxt;
    end
  end

  // stage G: rounding numerator 2m + den over 2 den
  logic           g_v_r, g_neg_r, g_zero_r;
  logic [N_W-1:0] g_n_r;
  logic [D_W-1:0] g_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (adv) begin
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_neg_r  <= f_neg_r;
      g_zero_r <= f_zero_r;
      g_n_r    <= {f_m_r, 1'b0} + {33'b0, f_den_r};
      g_d_r    <= {f_den_r, 1'b0};
    end
  end

  // stage H: overflow check, then 48 restoring divide stages
  logic           dv_v_r    [0:DIV_STAGES];
  logic [R_W-1:0] dv_rem_r  [0:DIV_STAGES];
  logic [D_W-1:0] dv_d_r    [0:DIV_STAGES];
  logic [Q_W-1:0] dv_q_r    [0:DIV_STAGES];
  logic           dv_ovf_r  [0:DIV_STAGES];
  logic           dv_neg_r  [0:DIV_STAGES];
  logic           dv_zero_r [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0]  <= {16'b0, g_n_r};
      dv_d_r[0]    <= g_d_r;
      dv_q_r[0]    <= '0;
      // quotient of 2^48 or more always saturates
      dv_ovf_r[0]  <= {16'b0, g_n_r} >= {g_d_r, 48'b0};
      dv_neg_r[0]  <= g_neg_r;
      dv_zero_r[0] <= g_zero_r;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [R_W-1:0] trial;
    logic           ge;

    always_comb begin
      trial = {48'b0, dv_d_r[j]} << (DIV_STAGES - 1 - j);
      ge    = dv_rem_r[j] >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[j+1]  <= ge ? (dv_rem_r[j] - trial) : dv_rem_r[j];
        dv_q_r[j+1]    <= {dv_q_r[j][Q_W-2:0], ge};
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_ovf_r[j+1]  <= dv_ovf_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
      end
    end
  end

  // output register: saturate, apply sign
  logic [Q_W-1:0] o_lim, o_mag, o_meas_nxt, o_meas_r;
  logic           o_sat, o_sat_nxt, o_sat_r;

  always_comb begin
    o_lim = dv_neg_r[DIV_STAGES] ? NEG_LIMIT : POS_LIMIT;
    o_sat = dv_ovf_r[DIV_STAGES] || (dv_q_r[DIV_STAGES] > o_lim);
    o_mag = o_sat ? o_lim : dv_q_r[DIV_STAGES];
    if (dv_zero_r[DIV_STAGES]) begin
      o_meas_nxt = '0;
      o_sat_nxt  = 1'b0;
    end else begin
      o_meas_nxt = dv_neg_r[DIV_STAGES] ? (~o_mag + 1'b1) : o_mag;
      o_sat_nxt  = o_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_meas_r <= o_meas_nxt;
      o_sat_r  <= o_sat_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.stress_measure = o_meas_r;
  assign out_ch.saturated      = o_sat_r;

endmodule

[sv/isi_checker.sv]
module isi_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [isi_pkg::T_W-1:0] stress_measure,
  input logic                           saturated
);
  import isi_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(stress_measure) && $stable(saturated))
    else $error("result beat changed while stalled");

  // a clamped result sits exactly on a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
      stress_measure == $signed(POS_LIMIT) || stress_measure == $signed(NEG_LIMIT))
    else $error("saturated result not at a limit");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ice_stress_invariant isi_checker u_isi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .stress_measure (out_ch.stress_measure),
  .saturated      (out_ch.saturated)
);
